FILE: hdl/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
// Depends on nothing; every module of the unit imports it.
package cau_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
  localparam int ITER_STAGES  = 32;
  localparam int LATENCY      = 4 + ITER_STAGES + 1;

  localparam int CW   = 60;                       // CORDIC x/y width
  localparam int ZW   = 34;                       // angle accumulator width
  localparam int RW   = 64 + FRAC_BITS;           // divider remainder width
  localparam int CMPW = 64 + ITER_STAGES + 1;     // divider compare width
  localparam int SW   = 66;                       // square root compare width

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_ARG = 3'd5
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [ZW-1:0] Z_90    = ZW'(64'sd90 <<< ANG_FRAC);
  localparam logic signed [ZW-1:0] Z_180   = ZW'(64'sd180 <<< ANG_FRAC);
  localparam logic signed [ZW-1:0] ANG_RND = ZW'((1 << ANG_SH) >> 1);

  // atan(2^-i) in units of 2^-24 degree
  localparam logic signed [ZW-1:0] ANG_TABLE [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [2:0]           op;
    logic [31:0]          cre;
    logic [31:0]          cim;
    logic                 csat;
    logic                 dz;
    logic [63:0]          den;
    logic [RW-1:0]        rre;
    logic [RW-1:0]        rim;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [31:0]          qre;
    logic [31:0]          qim;
    logic [63:0]          srem;
    logic [31:0]          root;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic                 skip;
  } pipe_t;

  // {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: hdl/cau_front.sv
// Front end of the unit: input capture, products, wide sums and range checks.
// Four register stages; loads the iteration word. Depends on cau_pkg.
module cau_front import cau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               valid_o,
  output pipe_t              pipe_o
);

  logic va_q, vb_q, vc_q, vd_q;
  logic [2:0] opa_q, opb_q, opc_q;
  logic signed [31:0] ar_q, ai_q, br_q, bi_q;

  logic signed [31:0] s0, s1;
  logic signed [63:0] p0_d, p1_d, p2_d, p3_d, sq0_d, sq1_d;
  logic signed [63:0] p0_q, p1_q, p2_q, p3_q, sq0_q, sq1_q;
  logic signed [32:0] sre_d, sim_d, sre_q, sim_q;
  logic signed [32:0] xe, ye;
  logic signed [CW-1:0] cxb_d, cyb_d, cxb_q, cyb_q, cxc_q, cyc_q;
  logic signed [ZW-1:0] czb_d, czb_q, czc_q;
  logic skb_d, skb_q, skc_q;

  logic signed [64:0] mre_d, mim_d, nre_d, nim_d;
  logic signed [64:0] mre_q, mim_q, nre_q, nim_q;
  logic [63:0] sqs_d, sqs_q;
  logic [32:0] asre_d, asim_d, asre_q, asim_q;

  logic signed [64:0] mfre, mfim, nneg_re, nneg_im;
  logic [32:0] msre, msim;
  logic [63:0] mag_re, mag_im;
  logic [RW-1:0] rre, rim;
  pipe_t pipe_d, pipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= accept_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // products, add/sub, quadrant turn
  always_comb begin
    s0 = (opa_q == OP_MOD) ? ar_q : br_q;
    s1 = (opa_q == OP_MOD) ? ai_q : bi_q;
    p0_d  = 64'(ar_q) * 64'(br_q);
    p1_d  = 64'(ai_q) * 64'(bi_q);
    p2_d  = 64'(ar_q) * 64'(bi_q);
    p3_d  = 64'(ai_q) * 64'(br_q);
    sq0_d = 64'(s0) * 64'(s0);
    sq1_d = 64'(s1) * 64'(s1);
    if (opa_q == OP_SUB) begin
      sre_d = $signed({ar_q[31], ar_q}) - $signed({br_q[31], br_q});
      sim_d = $signed({ai_q[31], ai_q}) - $signed({bi_q[31], bi_q});
    end else begin
      sre_d = $signed({ar_q[31], ar_q}) + $signed({br_q[31], br_q});
      sim_d = $signed({ai_q[31], ai_q}) + $signed({bi_q[31], bi_q});
    end
    xe    = '0;
    ye    = '0;
    czb_d = '0;
    skb_d = 1'b0;
    if (ai_q == 0) begin
      skb_d = 1'b1;
      if (ar_q < 0) begin
        czb_d = Z_180;
      end
    end else if (ar_q == 0) begin
      skb_d = 1'b1;
      czb_d = (ai_q > 0) ? Z_90 : -Z_90;
    end else if (ar_q < 0) begin
      if (ai_q > 0) begin
        xe    = 33'(ai_q);
        ye    = -33'(ar_q);
        czb_d = Z_90;
      end else begin
        xe    = -33'(ai_q);
        ye    = 33'(ar_q);
        czb_d = -Z_90;
      end
    end else begin
      xe = 33'(ar_q);
      ye = 33'(ai_q);
    end
    cxb_d = CW'(xe) <<< ANG_FRAC;
    cyb_d = CW'(ye) <<< ANG_FRAC;
  end

  // sums of products
  always_comb begin
    mre_d  = 65'(p0_q) - 65'(p1_q);
    mim_d  = 65'(p2_q) + 65'(p3_q);
    nre_d  = 65'(p0_q) + 65'(p1_q);
    nim_d  = 65'(p3_q) - 65'(p2_q);
    sqs_d  = $unsigned(sq0_q) + $unsigned(sq1_q);
    asre_d = sat32(65'(sre_q));
    asim_d = sat32(65'(sim_q));
  end

  // scaling, magnitudes, overflow checks
  always_comb begin
    mfre    = mre_q >>> FRAC_BITS;
    mfim    = mim_q >>> FRAC_BITS;
    msre    = sat32(mfre);
    msim    = sat32(mfim);
    nneg_re = -nre_q;
    nneg_im = -nim_q;
    mag_re  = nre_q[64] ? nneg_re[63:0] : nre_q[63:0];
    mag_im  = nim_q[64] ? nneg_im[63:0] : nim_q[63:0];
    rre     = RW'(mag_re) << FRAC_BITS;
    rim     = RW'(mag_im) << FRAC_BITS;

    pipe_d.op = opc_q;
    if (opc_q == OP_MUL) begin
      pipe_d.cre  = msre[31:0];
      pipe_d.cim  = msim[31:0];
      pipe_d.csat = msre[32] | msim[32];
    end else begin
      pipe_d.cre  = asre_q[31:0];
      pipe_d.cim  = asim_q[31:0];
      pipe_d.csat = asre_q[32] | asim_q[32];
    end
    pipe_d.dz     = (sqs_q == '0);
    pipe_d.den    = sqs_q;
    pipe_d.rre    = rre;
    pipe_d.rim    = rim;
    pipe_d.neg_re = nre_q[64];
    pipe_d.neg_im = nim_q[64];
    pipe_d.ovf_re = CMPW'(rre) >= (CMPW'(sqs_q) << ITER_STAGES);
    pipe_d.ovf_im = CMPW'(rim) >= (CMPW'(sqs_q) << ITER_STAGES);
    pipe_d.qre    = '0;
    pipe_d.qim    = '0;
    pipe_d.srem   = sqs_q;
    pipe_d.root   = '0;
    pipe_d.cx     = cxc_q;
    pipe_d.cy     = cyc_q;
    pipe_d.cz     = czc_q;
    pipe_d.skip   = skc_q;
  end

  always_ff @(posedge clk_i) begin
    opa_q  <= opcode_i;
    ar_q   <= a_re_i;
    ai_q   <= a_im_i;
    br_q   <= b_re_i;
    bi_q   <= b_im_i;

    opb_q  <= opa_q;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    p3_q   <= p3_d;
    sq0_q  <= sq0_d;
    sq1_q  <= sq1_d;
    sre_q  <= sre_d;
    sim_q  <= sim_d;
    cxb_q  <= cxb_d;
    cyb_q  <= cyb_d;
    czb_q  <= czb_d;
    skb_q  <= skb_d;

    opc_q  <= opb_q;
    mre_q  <= mre_d;
    mim_q  <= mim_d;
    nre_q  <= nre_d;
    nim_q  <= nim_d;
    sqs_q  <= sqs_d;
    asre_q <= asre_d;
    asim_q <= asim_d;
    cxc_q  <= cxb_q;
    cyc_q  <= cyb_q;
    czc_q  <= czb_q;
    skc_q  <= skb_q;

    pipe_q <= pipe_d;
  end

  assign valid_o = vd_q;
  assign pipe_o  = pipe_q;

endmodule

FILE: hdl/cau_iter.sv
// Iteration pipeline: one restoring divide bit and one square root bit per
// stage, and one CORDIC vectoring step per stage below CORDIC_STEPS. Depends on cau_pkg.
module cau_iter import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  pipe_t pipe_i,
  output logic  valid_o,
  output pipe_t pipe_o
);

  pipe_t stg_q [ITER_STAGES];
  logic  vld_q [ITER_STAGES];

  for (genvar j = 0; j < ITER_STAGES; j++) begin : g_stage
    localparam int K = ITER_STAGES - 1 - j;
    pipe_t cur, nxt;
    logic  vin;
    logic [CMPW-1:0] dsh;
    logic [SW-1:0] trial;
    logic signed [CW-1:0] dx, dy;

    if (j == 0) begin : g_first
      assign cur = pipe_i;
      assign vin = valid_i;
    end else begin : g_next
      assign cur = stg_q[j-1];
      assign vin = vld_q[j-1];
    end

    always_comb begin
      nxt   = cur;
      dsh   = CMPW'(cur.den) << K;
      trial = (SW'(cur.root) << (K + 1)) | (SW'(1) << (2 * K));
      dx    = cur.cy >>> j;
      dy    = cur.cx >>> j;
      if (CMPW'(cur.rre) >= dsh) begin
        nxt.rre    = cur.rre - dsh[RW-1:0];
        nxt.qre[K] = 1'b1;
      end
      if (CMPW'(cur.rim) >= dsh) begin
        nxt.rim    = cur.rim - dsh[RW-1:0];
        nxt.qim[K] = 1'b1;
      end
      if (SW'(cur.srem) >= trial) begin
        nxt.srem    = cur.srem - trial[63:0];
        nxt.root[K] = 1'b1;
      end
      if ((j < CORDIC_STEPS) && !cur.skip) begin
        if (!cur.cy[CW-1]) begin
          nxt.cx = cur.cx + dx;
          nxt.cy = cur.cy - dy;
          nxt.cz = cur.cz + ANG_TABLE[j];
        end else begin
          nxt.cx = cur.cx - dx;
          nxt.cy = cur.cy + dy;
          nxt.cz = cur.cz - ANG_TABLE[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[j] <= nxt;
    end
  end

  assign valid_o = vld_q[ITER_STAGES-1];
  assign pipe_o  = stg_q[ITER_STAGES-1];

endmodule

FILE: hdl/cau_back.sv
// Back end: result selection, final rounding and saturation, output register.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  pipe_t       pipe_i,
  output logic        done_o,
  output logic [31:0] result_re_o,
  output logic [31:0] result_im_o,
  output logic [31:0] result_scalar_o,
  output logic [1:0]  status_o
);

  logic        done_q;
  logic [31:0] re_d, im_d, sc_d, re_q, im_q, sc_q;
  logic [1:0]  st_d, st_q;
  logic        sat;
  logic [32:0] dre, dim, zs;
  logic signed [ZW-1:0] zr;

  // {saturated, value} for a quotient magnitude below 2^32
  function automatic logic [32:0] div_fix(input logic [31:0] q, input logic neg,
                                          input logic ovf);
    logic [32:0] r;
    if (!neg) begin
      if (ovf || (q > 32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
      else                            r = {1'b0, q};
    end else begin
      if (ovf || (q > 32'h8000_0000)) r = {1'b1, 32'h8000_0000};
      else                            r = {1'b0, 32'd0 - q};
    end
    return r;
  endfunction

  always_comb begin
    dre  = div_fix(pipe_i.qre, pipe_i.neg_re, pipe_i.ovf_re);
    dim  = div_fix(pipe_i.qim, pipe_i.neg_im, pipe_i.ovf_im);
    zr   = (pipe_i.cz + ANG_RND) >>> ANG_SH;
    zs   = sat32(65'(zr));
    re_d = '0;
    im_d = '0;
    sc_d = '0;
    sat  = 1'b0;
    st_d = ST_OK;
    case (pipe_i.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        re_d = pipe_i.cre;
        im_d = pipe_i.cim;
        sat  = pipe_i.csat;
      end
      OP_DIV: begin
        if (pipe_i.dz) begin
          st_d = ST_DIV0;
        end else begin
          re_d = dre[31:0];
          im_d = dim[31:0];
          sat  = dre[32] | dim[32];
        end
      end
      OP_MOD: begin
        if (pipe_i.root[31]) begin
          sc_d = 32'h7FFF_FFFF;
          sat  = 1'b1;
        end else begin
          sc_d = pipe_i.root;
        end
      end
      OP_ARG: begin
        sc_d = zs[31:0];
        sat  = zs[32];
      end
      default: begin
      end
    endcase
    if (sat) st_d = ST_SAT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
    sc_q <= sc_d;
    st_q <= st_d;
  end

  assign done_o          = done_q;
  assign result_re_o     = re_q;
  assign result_im_o     = im_q;
  assign result_scalar_o = sc_q;
  assign status_o        = st_q;

endmodule

FILE: hdl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front end, iteration pipeline, back end.
// Depends on cau_pkg, cau_front, cau_iter and cau_back.
//
// Fully pipelined Q16.16 complex ALU. A word is taken on every cycle in which
// start_i is high (busy_o is never raised), and its result appears on done_o
// for one cycle, in issue order. A word passes through four front-end stages
// (capture, products, sums, range checks), the 32-stage iteration pipeline
// that produces the quotient and square root one bit per stage and runs the
// CORDIC steps alongside, and the output register. There is no back-pressure:
// the receiver must take every result.
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               done_o,
  output logic signed [31:0] result_re_o,
  output logic signed [31:0] result_im_o,
  output logic signed [31:0] result_scalar_o,
  output logic [1:0]         status_o
);

  logic  accept;
  logic  fv, iv;
  pipe_t fp, ip;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  cau_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (opcode_i),
    .a_re_i   (a_re_i),
    .a_im_i   (a_im_i),
    .b_re_i   (b_re_i),
    .b_im_i   (b_im_i),
    .valid_o  (fv),
    .pipe_o   (fp)
  );

  cau_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .pipe_i  (fp),
    .valid_o (iv),
    .pipe_o  (ip)
  );

  cau_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (iv),
    .pipe_i          (ip),
    .done_o          (done_o),
    .result_re_o     (result_re_o),
    .result_im_o     (result_im_o),
    .result_scalar_o (result_scalar_o),
    .status_o        (status_o)
  );

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result word without a matching issued word");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("issued word produced no result");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_DIV0 || status_o == ST_SAT))
    else $error("undefined status code");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DIV0) |->
      (result_re_o == '0 && result_im_o == '0 && result_scalar_o == '0))
    else $error("zero divisor result not cleared");

endmodule
